[rtl/sawarq_pkg.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ endpoint package
// Shared constants, codes and types for the endpoint controller and its queue.
// ----------------------------------------------------------------------------
package sawarq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HEADER_BYTES = 4;

  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam int WORD_W = 16;

  localparam logic [WORD_W-1:0] HDR_LEN  = WORD_W'(HEADER_BYTES);
  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_RX_HDR  = 2'd0,
    CMD_ENQ     = 2'd1,
    CMD_TX_SLOT = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_STALE_ACK = 4'd1,
    ST_SEQ_ERR   = 4'd2,
    ST_SHORT_HDR = 4'd3,
    ST_DUP_REACK = 4'd4,
    ST_QUEUE_FULL = 4'd5,
    ST_NO_SEND   = 4'd6,
    ST_HB_TIMEOUT = 4'd7,
    ST_CLOSED    = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CFG_RETRANSMIT_DELAY = 2'd0,
    CFG_ALIVE_TIMEOUT    = 2'd1,
    CFG_MAX_PAYLOAD      = 2'd2
  } cfg_idx_e;

  // One queued header descriptor.
  typedef struct packed {
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] seq;
  } entry_t;

  // Queue status seen by the controller.
  typedef struct packed {
    logic [QFILL_W-1:0] fill;
    logic               empty;
    logic               full;
  } qstat_t;

  // Input item payload, last field in the lowest bits.
  typedef struct packed {
    logic [WORD_W-1:0] payload_len;
    logic [WORD_W-1:0] rx_seq;
    logic [WORD_W-1:0] rx_len;
  } in_data_t;

  // Result item payload, last field in the lowest bits (56 bits, 7 bytes).
  typedef struct packed {
    logic              closed;
    logic [3:0]        status;
    logic [WORD_W-1:0] enq_seq;
    logic              deliver;
    logic              tx_retry;
    logic [WORD_W-1:0] tx_seq;
    logic [WORD_W-1:0] tx_len;
    logic              tx_valid;
  } out_data_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    return (v == WORD_MAX) ? v : v + WORD_W'(1);
  endfunction

endpackage

[rtl/sawarq_queue.sv]
// ----------------------------------------------------------------------------
// Transmit descriptor queue
// Circular FIFO of header descriptors with the head entry readable at once.
// ----------------------------------------------------------------------------
module sawarq_queue import sawarq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output entry_t head_entry_o,
  output qstat_t status_o
);

  localparam logic [QPTR_W-1:0]  LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QFILL_W-1:0] FULL_FILL = QFILL_W'(QUEUE_DEPTH);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  head_q, head_d;
  logic [QPTR_W-1:0]  tail_q, tail_d;
  logic [QFILL_W-1:0] fill_q, fill_d;
  logic               do_push, do_pop;

  function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + QPTR_W'(1);
  endfunction

  assign do_push = push_i && (fill_q != FULL_FILL);
  assign do_pop  = pop_i && (fill_q != '0);

  always_comb begin
    head_d = do_pop ? next_slot(head_q) : head_q;
    tail_d = do_push ? next_slot(tail_q) : tail_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + QFILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - QFILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= push_entry_i;
    end
  end

  assign head_entry_o    = mem_q[head_q];
  assign status_o.fill   = fill_q;
  assign status_o.empty  = (fill_q == '0);
  assign status_o.full   = (fill_q == FULL_FILL);

endmodule

[rtl/stop_and_wait_arq_endpoint_top.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ endpoint
// Header-level link controller with a transmit descriptor queue.
// ----------------------------------------------------------------------------
// The endpoint takes one event item per clock on the slave stream: a received
// header, a request to queue a data packet, a transmit slot or a timer tick,
// selected by tuser. Every item yields exactly one result item on the master
// stream, in order, after passing the input and output registers.
// An item is held in an input register, evaluated against the link counters
// and the head of the 16-entry transmit queue in one pass of logic, and the
// result lands in an output register; the sustained rate is one item per
// cycle, and back-pressure on the master side drops s_axis_tready in the same
// cycle while the input register is full. The three configuration registers
// are written through the separate cfg channel, which is always ready; write them
// only while no item is in flight. Once an error or heartbeat timeout closes the link,
// every further item reports link closed until reset.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_endpoint_top import sawarq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // rx_len[15:0], rx_seq[31:16], payload_len[47:32]
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // tx_valid[0], tx_len[16:1], tx_seq[32:17],
                                       // tx_retry[33], deliver[34], enq_seq[50:35],
                                       // status[54:51], closed[55]
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Input register stage.
  logic     in_valid_q;
  cmd_e     in_cmd_q;
  in_data_t in_data_q;

  // Output register stage.
  logic      out_valid_q;
  out_data_t out_data_q, out_data_d;

  // Configuration.
  logic [WORD_W-1:0] retransmit_delay_q, alive_timeout_q, max_payload_q;

  // Link state.
  logic [WORD_W-1:0] send_count_q, send_count_d;
  logic [WORD_W-1:0] ack_count_q, ack_count_d;
  logic [WORD_W-1:0] recv_expected_q, recv_expected_d;
  logic [WORD_W-1:0] last_data_seq_q, last_data_seq_d;
  logic [WORD_W-1:0] retry_ticks_q, retry_ticks_d;
  logic [WORD_W-1:0] idle_ticks_q, idle_ticks_d;
  logic              link_closed_q, link_closed_d;

  // Queue interface.
  logic   q_push, q_pop;
  entry_t q_push_entry, q_head;
  qstat_t q_stat;

  logic in_accept, advance;

  // Scratch values for the data-length and tick paths.
  logic [WORD_W-1:0] pay_clip;
  logic [WORD_W:0]   len_sum;
  logic [WORD_W-1:0] enq_len, enq_seq_new;
  logic [WORD_W-1:0] retry_inc, idle_inc;

  // The evaluation stage moves when there is an item and the output can take it.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser_i);
      in_data_q <= in_data_t'(s_axis_tdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retransmit_delay_q <= WORD_W'(3);
      alive_timeout_q    <= WORD_W'(30);
      max_payload_q      <= WORD_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RETRANSMIT_DELAY: retransmit_delay_q <= cfg_data_i;
        CFG_ALIVE_TIMEOUT:    alive_timeout_q    <= cfg_data_i;
        CFG_MAX_PAYLOAD:      max_payload_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Outbound data length: payload clipped to max_payload, plus the header,
  // saturating at the top of the 16-bit length field.
  assign pay_clip = (in_data_q.payload_len > max_payload_q) ? max_payload_q
                                                            : in_data_q.payload_len;
  assign len_sum  = {1'b0, HDR_LEN} + {1'b0, pay_clip};
  assign enq_len  = len_sum[WORD_W] ? WORD_MAX : len_sum[WORD_W-1:0];
  // A new data packet follows the last queued one, or the send counter when
  // nothing is queued.
  assign enq_seq_new = q_stat.empty ? send_count_q : last_data_seq_q + WORD_W'(1);

  assign retry_inc = sat_inc(retry_ticks_q);
  assign idle_inc  = sat_inc(idle_ticks_q);

  always_comb begin
    send_count_d    = send_count_q;
    ack_count_d     = ack_count_q;
    recv_expected_d = recv_expected_q;
    last_data_seq_d = last_data_seq_q;
    retry_ticks_d   = retry_ticks_q;
    idle_ticks_d    = idle_ticks_q;
    link_closed_d   = link_closed_q;
    q_push          = 1'b0;
    q_pop           = 1'b0;
    q_push_entry    = '{len: HDR_LEN, seq: recv_expected_q};
    out_data_d      = '0;
    out_data_d.status = ST_OK;

    if (link_closed_q) begin
      out_data_d.status = ST_CLOSED;
    end else begin
      case (in_cmd_q)
        CMD_RX_HDR: begin
          idle_ticks_d = '0;
          if (in_data_q.rx_len < HDR_LEN) begin
            out_data_d.status = ST_SHORT_HDR;
            link_closed_d     = 1'b1;
          end else if (in_data_q.rx_len == HDR_LEN) begin
            // Received ACK: only the one for the outstanding packet counts.
            if (in_data_q.rx_seq < ack_count_q) begin
              out_data_d.status = ST_STALE_ACK;
            end else if (in_data_q.rx_seq > ack_count_q || send_count_q == ack_count_q) begin
              out_data_d.status = ST_SEQ_ERR;
              link_closed_d     = 1'b1;
            end else begin
              q_pop       = 1'b1;
              ack_count_d = ack_count_q + WORD_W'(1);
            end
          end else begin
            // Received data.
            if (in_data_q.rx_seq < recv_expected_q) begin
              // A duplicate is acknowledged straight away with its own number.
              out_data_d.tx_valid = 1'b1;
              out_data_d.tx_len   = HDR_LEN;
              out_data_d.tx_seq   = in_data_q.rx_seq;
              out_data_d.status   = ST_DUP_REACK;
            end else if (in_data_q.rx_seq > recv_expected_q) begin
              out_data_d.status = ST_SEQ_ERR;
              link_closed_d     = 1'b1;
            end else if (q_stat.full) begin
              // No room for the ACK: drop it so the peer's resend is taken.
              out_data_d.status = ST_QUEUE_FULL;
            end else begin
              q_push              = 1'b1;
              out_data_d.enq_seq  = recv_expected_q;
              out_data_d.deliver  = 1'b1;
              recv_expected_d     = recv_expected_q + WORD_W'(1);
            end
          end
        end

        CMD_ENQ: begin
          if (q_stat.full) begin
            out_data_d.status = ST_QUEUE_FULL;
          end else begin
            q_push             = 1'b1;
            q_push_entry       = '{len: enq_len, seq: enq_seq_new};
            out_data_d.enq_seq = enq_seq_new;
            // An empty payload travels like an ACK and does not advance the
            // data numbering.
            if (enq_len > HDR_LEN) begin
              last_data_seq_d = enq_seq_new;
            end
          end
        end

        CMD_TX_SLOT: begin
          if (q_stat.empty || send_count_q != ack_count_q) begin
            out_data_d.status = ST_NO_SEND;
          end else begin
            out_data_d.tx_valid = 1'b1;
            out_data_d.tx_len   = q_head.len;
            out_data_d.tx_seq   = q_head.seq;
            if (q_head.len == HDR_LEN) begin
              q_pop = 1'b1;
            end else begin
              // Data stays queued until its ACK arrives.
              send_count_d  = send_count_q + WORD_W'(1);
              retry_ticks_d = '0;
            end
          end
        end

        CMD_TICK: begin
          retry_ticks_d = retry_inc;
          idle_ticks_d  = idle_inc;
          if (send_count_q != ack_count_q && !q_stat.empty &&
              retry_inc > retransmit_delay_q) begin
            out_data_d.tx_valid = 1'b1;
            out_data_d.tx_len   = q_head.len;
            out_data_d.tx_seq   = q_head.seq;
            out_data_d.tx_retry = 1'b1;
            retry_ticks_d       = '0;
          end
          if (idle_inc > alive_timeout_q) begin
            out_data_d.status = ST_HB_TIMEOUT;
            link_closed_d     = 1'b1;
          end
        end

        default: ;
      endcase
    end

    out_data_d.closed = link_closed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_count_q    <= '0;
      ack_count_q     <= '0;
      recv_expected_q <= '0;
      last_data_seq_q <= WORD_MAX;
      retry_ticks_q   <= '0;
      idle_ticks_q    <= '0;
      link_closed_q   <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (advance) begin
        send_count_q    <= send_count_d;
        ack_count_q     <= ack_count_d;
        recv_expected_q <= recv_expected_d;
        last_data_seq_q <= last_data_seq_d;
        retry_ticks_q   <= retry_ticks_d;
        idle_ticks_q    <= idle_ticks_d;
        link_closed_q   <= link_closed_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  sawarq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push && advance),
    .push_entry_i (q_push_entry),
    .pop_i        (q_pop && advance),
    .head_entry_o (q_head),
    .status_o     (q_stat)
  );

endmodule
